// ===== src/cgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgb_pkg
// Shared types and constants for the clipped glyph row blitter.
// ----------------------------------------------------------------------------
package cgb_pkg;

	// framebuffer pitch in pixel addresses per row
	localparam int PITCH         = 1024;
	localparam int MAX_GLYPH_DIM = 16;
	localparam int DIM_CAP       = (MAX_GLYPH_DIM < 16) ? MAX_GLYPH_DIM : 16;

	localparam int DIM_W   = 5;
	localparam int GBITS_W = 9;
	localparam int CLIP_W  = 11;
	localparam int COLOR_W = 4;
	localparam int CODE_W  = 8;
	localparam int POS_W   = 12;
	localparam int FADDR_W = 13;
	localparam int BYTE_W  = 8;
	localparam int MASK_W  = 16;
	localparam int ADDR_W  = 22;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 11;
	localparam int COORD_W = 14;
	localparam int BASE_W  = 17;
	localparam int BUF_W   = 32;
	localparam int CNT_W   = 6;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_DRAW = 1'b1;

	typedef enum logic [CIDX_W-1:0] {
		REG_CHAR_WIDTH,
		REG_CHAR_HEIGHT,
		REG_GLYPH_BITS,
		REG_CLIP_LEFT,
		REG_CLIP_TOP,
		REG_CLIP_RIGHT,
		REG_CLIP_BOTTOM,
		REG_COLOR_INDEX
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_START,
		ST_RUN,
		ST_UL
	} state_t;

	// clamped glyph geometry and clip setup
	typedef struct packed {
		logic [DIM_W-1:0]   w;
		logic [DIM_W-1:0]   h;
		logic [GBITS_W-1:0] glyph_bits;
		logic [CLIP_W-1:0]  clip_left;
		logic [CLIP_W-1:0]  clip_top;
		logic [CLIP_W-1:0]  clip_right;
		logic [CLIP_W-1:0]  clip_bottom;
		logic [COLOR_W-1:0] color;
	} cfg_t;

endpackage

// ===== src/cgb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cgb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/cgb_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgb_cfg
// Configuration register file with glyph size clamping.
// ----------------------------------------------------------------------------
module cgb_cfg
	import cgb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [CDATA_W-1:0] cfg_data,
	output cfg_t               cfg
);

	localparam logic [DIM_W-1:0] CAP = DIM_W'(DIM_CAP);

	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [GBITS_W-1:0] gbits_q;
	logic [CLIP_W-1:0]  left_q;
	logic [CLIP_W-1:0]  top_q;
	logic [CLIP_W-1:0]  right_q;
	logic [CLIP_W-1:0]  bottom_q;
	logic [COLOR_W-1:0] color_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(8);
			height_q <= DIM_W'(8);
			gbits_q  <= GBITS_W'(64);
			left_q   <= '0;
			top_q    <= '0;
			right_q  <= CLIP_W'(1024);
			bottom_q <= CLIP_W'(1024);
			color_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CHAR_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				REG_CHAR_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				REG_GLYPH_BITS:  gbits_q  <= cfg_data[GBITS_W-1:0];
				REG_CLIP_LEFT:   left_q   <= cfg_data[CLIP_W-1:0];
				REG_CLIP_TOP:    top_q    <= cfg_data[CLIP_W-1:0];
				REG_CLIP_RIGHT:  right_q  <= cfg_data[CLIP_W-1:0];
				REG_CLIP_BOTTOM: bottom_q <= cfg_data[CLIP_W-1:0];
				REG_COLOR_INDEX: color_q  <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg = '0;
		cfg.w = (width_q == '0) ? DIM_W'(1) : ((width_q > CAP) ? CAP : width_q);
		cfg.h = (height_q == '0) ? DIM_W'(1) : ((height_q > CAP) ? CAP : height_q);
		cfg.glyph_bits  = gbits_q;
		cfg.clip_left   = left_q;
		cfg.clip_top    = top_q;
		cfg.clip_right  = right_q;
		cfg.clip_bottom = bottom_q;
		cfg.color       = color_q;
	end

endmodule

// ===== src/cgb_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgb_seq
// Draw sequencer: streams glyph bytes from the font RAM into a bit buffer,
// slices it into glyph rows, clips and drives the output register.
// ----------------------------------------------------------------------------
module cgb_seq
	import cgb_pkg::*;
#(
	parameter int FONT_BYTES = 8192
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cfg_t                             cfg,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             func,
	input  logic [FADDR_W-1:0]               font_addr,
	input  logic [BYTE_W-1:0]                font_byte,
	input  logic [CODE_W-1:0]                glyph_code,
	input  logic signed [POS_W-1:0]          pos_x,
	input  logic signed [POS_W-1:0]          pos_y,
	input  logic                             underline,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [ADDR_W-1:0]         pixel_address,
	output logic [MASK_W-1:0]                write_mask,
	output logic [COLOR_W-1:0]               write_color,
	output logic                             last,
	output logic                             mem_we,
	output logic [$clog2(FONT_BYTES)-1:0]    mem_waddr,
	output logic [BYTE_W-1:0]                mem_wdata,
	output logic                             mem_re,
	output logic [$clog2(FONT_BYTES)-1:0]    mem_raddr,
	input  logic [BYTE_W-1:0]                mem_rdata
);

	localparam int AW        = $clog2(FONT_BYTES);
	localparam int RED_STEPS = (16 - AW > 0) ? (16 - AW) : 1;
	localparam logic [AW-1:0]     PTR_LAST = AW'(FONT_BYTES - 1);
	localparam logic [ADDR_W-1:0] PITCH_A  = ADDR_W'(PITCH);
	localparam logic [CNT_W-1:0]  FILL_MAX = CNT_W'(BUF_W - BYTE_W);

	// wrap a byte index into the font store by conditional subtracts
	function automatic logic [AW-1:0] font_wrap(input logic [15:0] v);
		logic [16:0] t;
		t = {1'b0, v};
		for (int k = RED_STEPS - 1; k >= 0; k--) begin
			if (32'(t) >= (FONT_BYTES << k)) begin
				t = t - 17'(FONT_BYTES << k);
			end
		end
		return t[AW-1:0];
	endfunction

	state_t state_q, state_d;

	logic [CODE_W-1:0]         code_q;
	logic [POS_W-1:0]          x_q;
	logic signed [COORD_W-1:0] row_y_q;
	logic [MASK_W-1:0]         hmask_q;
	logic                      ul_emit_q;
	logic [BASE_W-1:0]         base_q;
	logic [ADDR_W-1:0]         addr_q;
	logic [AW-1:0]             ptr_q;
	logic [2:0]                off_q;
	logic [BUF_W-1:0]          buf_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      pend_q;
	logic                      first_q;
	logic [DIM_W-1:0]          r_q;

	logic                      out_valid_q;
	logic [ADDR_W-1:0]         out_addr_q;
	logic [MASK_W-1:0]         out_mask_q;
	logic [COLOR_W-1:0]        out_color_q;
	logic                      out_last_q;

	logic                      accept;
	logic                      is_draw;
	logic signed [COORD_W-1:0] sx, sy, xw, yh;
	logic signed [COORD_W-1:0] cl, ct, cr, cb;
	logic                      reject;
	logic                      ul_ok;
	logic [MASK_W-1:0]         hmask_c;
	logic                      out_free;
	logic                      consume;
	logic                      row_done;
	logic                      row_in_clip;
	logic                      row_last;
	logic                      emit;
	logic [ADDR_W-1:0]         emit_addr;
	logic [MASK_W-1:0]         emit_mask;
	logic                      emit_last;
	logic [BUF_W-1:0]          buf_c, buf_n;
	logic [CNT_W-1:0]          cnt_c, cnt_n;
	logic [BYTE_W-1:0]         app_byte;
	logic [CNT_W-1:0]          app_n;
	logic [BUF_W+BYTE_W-1:0]   app_sh;
	logic [ADDR_W-1:0]         addr0;

	assign accept  = in_valid && !in_stall;
	assign is_draw = (func == FUNC_DRAW);

	// clip tests on the incoming draw
	always_comb begin
		sx = COORD_W'(pos_x);
		sy = COORD_W'(pos_y);
		cl = $signed({3'b000, cfg.clip_left});
		ct = $signed({3'b000, cfg.clip_top});
		cr = $signed({3'b000, cfg.clip_right});
		cb = $signed({3'b000, cfg.clip_bottom});
		xw = sx + $signed({{(COORD_W-DIM_W){1'b0}}, cfg.w});
		yh = sy + $signed({{(COORD_W-DIM_W){1'b0}}, cfg.h});
		reject = (xw < cl) || (sx > cr) || (yh < ct) || (sy > cb);
		ul_ok  = underline && (yh >= ct) && (yh < cb);
		for (int j = 0; j < MASK_W; j++) begin
			hmask_c[j] = (DIM_W'(j) < cfg.w) &&
				((sx + COORD_W'(j)) >= cl) && ((sx + COORD_W'(j)) < cr);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_draw && !reject) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_START;
			end
			ST_START: begin
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (consume && row_done) begin
					state_d = ul_emit_q ? ST_UL : ST_IDLE;
				end
			end
			ST_UL: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall    = (state_q != ST_IDLE);
		out_free    = !out_valid_q || !out_stall;
		row_done    = (r_q == cfg.h - DIM_W'(1));
		row_in_clip = (row_y_q >= ct) && (row_y_q < cb);
		row_last    = !ul_emit_q && (row_done || ((row_y_q + COORD_W'(1)) >= cb));
		consume     = 1'b0;
		emit        = 1'b0;
		emit_addr   = addr_q;
		emit_mask   = buf_q[MASK_W-1:0] & hmask_q;
		emit_last   = row_last;
		unique case (state_q)
			ST_RUN: begin
				consume = out_free && (cnt_q >= CNT_W'(cfg.w));
				emit    = consume && row_in_clip;
			end
			ST_UL: begin
				emit      = out_free;
				emit_mask = hmask_q;
				emit_last = 1'b1;
			end
			default: ;
		endcase
		mem_we    = accept && (func == FUNC_LOAD);
		mem_waddr = font_wrap(16'(font_addr));
		mem_wdata = font_byte;
		mem_re    = (state_q == ST_RUN) && !(consume && row_done) && (cnt_n <= FILL_MAX);
		mem_raddr = ptr_q;
	end

	// bit buffer update
	always_comb begin
		buf_c    = consume ? (buf_q >> cfg.w) : buf_q;
		cnt_c    = consume ? (cnt_q - CNT_W'(cfg.w)) : cnt_q;
		app_byte = first_q ? (mem_rdata >> off_q) : mem_rdata;
		app_n    = first_q ? (CNT_W'(BYTE_W) - CNT_W'(off_q)) : CNT_W'(BYTE_W);
		app_sh   = (BUF_W+BYTE_W)'(app_byte) << cnt_c;
		buf_n    = pend_q ? (buf_c | app_sh[BUF_W-1:0]) : buf_c;
		cnt_n    = pend_q ? (cnt_c + app_n) : cnt_c;
	end

	assign addr0 = ({{(ADDR_W-POS_W){row_y_q[POS_W-1]}}, row_y_q[POS_W-1:0]} * PITCH_A)
		+ {{(ADDR_W-POS_W){x_q[POS_W-1]}}, x_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			pend_q <= mem_re;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_addr_q  <= emit_addr;
			out_mask_q  <= emit_mask;
			out_color_q <= cfg.color;
			out_last_q  <= emit_last;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					code_q    <= glyph_code;
					x_q       <= pos_x;
					row_y_q   <= sy;
					hmask_q   <= hmask_c;
					ul_emit_q <= ul_ok;
				end
			end
			ST_MUL: begin
				base_q <= BASE_W'(code_q) * BASE_W'(cfg.glyph_bits);
				addr_q <= addr0;
			end
			ST_START: begin
				ptr_q   <= font_wrap(16'(base_q[BASE_W-1:3]));
				off_q   <= base_q[2:0];
				buf_q   <= '0;
				cnt_q   <= '0;
				first_q <= 1'b1;
				r_q     <= '0;
			end
			ST_RUN: begin
				buf_q <= buf_n;
				cnt_q <= cnt_n;
				if (pend_q) begin
					first_q <= 1'b0;
				end
				if (mem_re) begin
					ptr_q <= (ptr_q == PTR_LAST) ? '0 : ptr_q + AW'(1);
				end
				if (consume) begin
					r_q     <= r_q + DIM_W'(1);
					row_y_q <= row_y_q + COORD_W'(1);
					addr_q  <= addr_q + PITCH_A;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign pixel_address = out_addr_q;
	assign write_mask    = out_mask_q;
	assign write_color   = out_color_q;
	assign last          = out_last_q;

endmodule

// ===== src/clipped_glyph_row_blitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_glyph_row_blitter
// Draws one bitmap-font glyph as masked row writes, clipped to a rectangle.
// ----------------------------------------------------------------------------
// A load transaction writes one font byte and the block is ready again at
// once. A draw transaction is taken only when the block is idle; a glyph
// that misses the clip rectangle is dropped in that same cycle. Otherwise
// the glyph bits are streamed from the font RAM, one byte per cycle while
// the bit buffer has room, and at most one row write leaves per cycle. A
// draw passes through the MUL state (glyph base and first row address), the
// START state (font pointer and bit offset of the glyph in its first font
// byte), the RUN state (rows sliced from the bit buffer) and, for an
// underline, the UL state; a stalled row write holds the sequencer. The
// single read port of the font RAM and the output of at most one row per
// cycle limit how fast a draw proceeds. Rows are sent through an output
// register, so the next transaction can be taken while the final row write
// of a glyph still waits downstream.
// ----------------------------------------------------------------------------
module clipped_glyph_row_blitter
	import cgb_pkg::*;
#(
	parameter int FONT_BYTES = 8192
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CIDX_W-1:0]        cfg_index,
	input  logic [CDATA_W-1:0]       cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     func,
	input  logic [FADDR_W-1:0]       font_addr,
	input  logic [BYTE_W-1:0]        font_byte,
	input  logic [CODE_W-1:0]        glyph_code,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic                     underline,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [ADDR_W-1:0] pixel_address,
	output logic [MASK_W-1:0]        write_mask,
	output logic [COLOR_W-1:0]       write_color,
	output logic                     last
);

	localparam int AW = $clog2(FONT_BYTES);

	cfg_t              cfg;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [BYTE_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [BYTE_W-1:0] mem_rdata;

	cgb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cgb_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (FONT_BYTES)
	) u_font (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	cgb_seq #(
		.FONT_BYTES (FONT_BYTES)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.font_addr     (font_addr),
		.font_byte     (font_byte),
		.glyph_code    (glyph_code),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.underline     (underline),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_address (pixel_address),
		.write_mask    (write_mask),
		.write_color   (write_color),
		.last          (last),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_re        (mem_re),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata)
	);

endmodule

// ===== src/cgb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgb_checker
// Port level checks for the clipped glyph row blitter.
// ----------------------------------------------------------------------------
module cgb_checker
	import cgb_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     func,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [ADDR_W-1:0] pixel_address,
	input logic [MASK_W-1:0]        write_mask,
	input logic [COLOR_W-1:0]       write_color,
	input logic                     last
);

	// stalled row write holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_address) &&
		$stable(write_mask) && $stable(write_color) && $stable(last))
		else $error("row write changed while stalled");

	// a font load leaves the block ready
	a_load_single: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func == FUNC_LOAD |=> !in_stall)
		else $error("font load did not complete in one cycle");

	// rows before the final one belong to a glyph still in progress
	a_mid_glyph_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("non-final row write with block idle");

endmodule

bind clipped_glyph_row_blitter cgb_checker u_cgb_checker (.*);
